// ===== rtl/core/gfps_pkg.sv =====
// gfps_pkg: shared widths, register indices and the sideband type for the
// ghost-fluid stencil datapath. No dependencies.
package gfps_pkg;

    localparam int LEVEL_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int QW        = 24;
    localparam int SUM_W     = 27;
    localparam int NLANE     = 6;
    localparam int NSTG      = QW + 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    localparam logic [QW-1:0] FRAC_SAT = {QW{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAC_MIN = 2'd0,
        CFG_FRAC_MAX = 2'd1,
        CFG_TWO_DIM  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic active;
        logic x_link;
        logic y_link;
        logic z_link;
    } t_side;

endpackage

// ===== rtl/core/gfps_cell_if.sv =====
// gfps_cell_if: valid/ready channel carrying one grid cell
// depends on gfps_pkg for widths
interface gfps_cell_if;
    logic valid;
    logic ready;
    logic signed [gfps_pkg::LEVEL_W-1:0] center_level;
    logic signed [gfps_pkg::LEVEL_W-1:0] level_x_minus;
    logic signed [gfps_pkg::LEVEL_W-1:0] level_x_plus;
    logic signed [gfps_pkg::LEVEL_W-1:0] level_y_minus;
    logic signed [gfps_pkg::LEVEL_W-1:0] level_y_plus;
    logic signed [gfps_pkg::LEVEL_W-1:0] level_z_minus;
    logic signed [gfps_pkg::LEVEL_W-1:0] level_z_plus;
    logic        center_solid;
    logic [5:0]  neighbour_solid_mask;

    modport source (output valid, center_level, level_x_minus, level_x_plus,
                    level_y_minus, level_y_plus, level_z_minus, level_z_plus,
                    center_solid, neighbour_solid_mask, input ready);
    modport sink   (input valid, center_level, level_x_minus, level_x_plus,
                    level_y_minus, level_y_plus, level_z_minus, level_z_plus,
                    center_solid, neighbour_solid_mask, output ready);
endinterface

// ===== rtl/core/gfps_row_if.sv =====
// gfps_row_if: valid/ready channel carrying one stencil row result
// depends on gfps_pkg for widths
interface gfps_row_if;
    logic valid;
    logic ready;
    logic                        active;
    logic [gfps_pkg::SUM_W-1:0]  ghost_diag_sum;
    logic                        x_link;
    logic                        y_link;
    logic                        z_link;

    modport source (output valid, active, ghost_diag_sum, x_link, y_link, z_link,
                    input ready);
    modport sink   (input valid, active, ghost_diag_sum, x_link, y_link, z_link,
                    output ready);
endinterface

// ===== rtl/core/gfps_lane.sv =====
// gfps_lane: one neighbour lane, pipelined restoring divider for the inverse
// interface fraction followed by saturation and clamp. Uses gfps_pkg.
module gfps_lane (
    input  logic                            i_clk,
    input  logic [gfps_pkg::NSTG-1:0]       i_en,
    input  logic [gfps_pkg::LEVEL_W-1:0]    i_a,
    input  logic signed [gfps_pkg::LEVEL_W-1:0] i_level,
    input  logic                            i_use,
    input  logic [gfps_pkg::QW-1:0]         i_min,
    input  logic [gfps_pkg::QW-1:0]         i_max,
    output logic [gfps_pkg::QW-1:0]         o_frac
);
    localparam int LW = gfps_pkg::LEVEL_W;
    localparam int QW = gfps_pkg::QW;
    localparam int DW = LW + gfps_pkg::FRAC_BITS;
    localparam int XW = LW + QW;

    logic [LW-1:0] r_a   [QW+1];
    logic [LW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_use [QW+1];
    logic          r_sat [QW+1];
    logic [QW-1:0] r_frac;

    logic [LW-1:0] w_sum;
    logic [DW-1:0] w_d;
    logic [XW-1:0] w_thr;
    logic          w_use;

    // dividend (a + n) << frac and saturation test against a << 24
    always_comb begin
        w_sum = i_a + LW'(i_level);
        w_d   = {w_sum, {gfps_pkg::FRAC_BITS{1'b0}}};
        w_thr = XW'(i_a) << QW;
        w_use = i_use && !i_level[LW-1];
    end

    // entry stage
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a[0]   <= i_a;
            r_rem[0] <= LW'(w_d >> QW);
            r_low[0] <= w_d[QW-1:0];
            r_q[0]   <= '0;
            r_use[0] <= w_use;
            r_sat[0] <= XW'(w_d) >= w_thr;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QW; k++) begin : g_div
        logic [LW:0]   w_t;
        logic          w_ge;
        logic [LW:0]   w_diff;
        always_comb begin
            w_t    = {r_rem[k-1], r_low[k-1][QW-1]};
            w_ge   = w_t >= {1'b0, r_a[k-1]};
            w_diff = w_t - {1'b0, r_a[k-1]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_a[k]   <= r_a[k-1];
                r_rem[k] <= w_ge ? w_diff[LW-1:0] : w_t[LW-1:0];
                r_low[k] <= {r_low[k-1][QW-2:0], 1'b0};
                r_q[k]   <= {r_q[k-1][QW-2:0], w_ge};
                r_use[k] <= r_use[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    // saturate, clamp, gate by use
    logic [QW-1:0] w_qs;
    logic [QW-1:0] w_hi;
    logic [QW-1:0] w_cl;
    always_comb begin
        w_qs = r_sat[QW] ? gfps_pkg::FRAC_SAT : r_q[QW];
        w_hi = (w_qs > i_max) ? i_max : w_qs;
        w_cl = (w_hi < i_min) ? i_min : w_hi;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[QW+1]) begin
            r_frac <= r_use[QW] ? w_cl : '0;
        end
    end

    assign o_frac = r_frac;
endmodule

// ===== rtl/core/gfps_merge.sv =====
// gfps_merge: adds the six lane fractions and holds the result in the
// output register. Uses gfps_pkg and gfps_row_if.
module gfps_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [gfps_pkg::QW-1:0]   i_frac [gfps_pkg::NLANE],
    input  gfps_pkg::t_side           i_side,
    output logic                      o_en,
    gfps_row_if.source                o_row
);
    localparam int SW = gfps_pkg::SUM_W;

    logic          r_valid;
    logic [SW-1:0] r_sum;
    gfps_pkg::t_side r_side;
    logic [SW-1:0] w_sum;

    // register can load when empty or being drained
    assign o_en = !r_valid || o_row.ready;

    // lane sum
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < gfps_pkg::NLANE; i++) begin
            w_sum = w_sum + SW'(i_frac[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_sum  <= w_sum;
            r_side <= i_side;
        end
    end

    assign o_row.valid          = r_valid;
    assign o_row.active         = r_side.active;
    assign o_row.ghost_diag_sum = r_sum;
    assign o_row.x_link         = r_side.x_link;
    assign o_row.y_link         = r_side.y_link;
    assign o_row.z_link         = r_side.z_link;
endmodule

// ===== rtl/core/ghost_fluid_poisson_stencil_top.sv =====
// Ghost-fluid Poisson stencil row builder: one grid cell in, one row out.
// Depends on gfps_pkg, gfps_cell_if, gfps_row_if, gfps_lane and gfps_merge.
// A new cell is taken every cycle while the entry stage can advance; each
// result passes one entry stage, 24 divider stages, one clamp stage and the
// output register. Six lanes, one per neighbour, each run a restoring
// divider that yields one quotient bit per stage; every stage can fill its
// own bubble, so a stalled output only holds the cells behind it.
module ghost_fluid_poisson_stencil_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gfps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gfps_pkg::CFG_W-1:0]          i_cfg_data,
    gfps_cell_if.sink                           i_cell,
    gfps_row_if.source                          o_row
);
    localparam int NSTG = gfps_pkg::NSTG;
    localparam int LW   = gfps_pkg::LEVEL_W;
    localparam int QW   = gfps_pkg::QW;

    logic [QW-1:0] r_min;
    logic [QW-1:0] r_max;
    logic          r_2d;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= QW'(1) << gfps_pkg::FRAC_BITS;
            r_max <= gfps_pkg::FRAC_SAT;
            r_2d  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gfps_pkg::CFG_FRAC_MIN: r_min <= i_cfg_data[QW-1:0];
                gfps_pkg::CFG_FRAC_MAX: r_max <= i_cfg_data[QW-1:0];
                gfps_pkg::CFG_TWO_DIM:  r_2d  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // cell classification
    logic                   w_active;
    logic [LW-1:0]          w_a;
    logic [gfps_pkg::NLANE-1:0] w_use;
    logic signed [LW-1:0]   w_lvl [gfps_pkg::NLANE];
    gfps_pkg::t_side        w_side;

    always_comb begin
        w_lvl[0] = i_cell.level_x_minus;
        w_lvl[1] = i_cell.level_x_plus;
        w_lvl[2] = i_cell.level_y_minus;
        w_lvl[3] = i_cell.level_y_plus;
        w_lvl[4] = i_cell.level_z_minus;
        w_lvl[5] = i_cell.level_z_plus;
        w_active = i_cell.center_level[LW-1] && !i_cell.center_solid;
        w_a      = LW'(~i_cell.center_level) + LW'(1);
        for (int i = 0; i < gfps_pkg::NLANE; i++) begin
            w_use[i] = w_active && !i_cell.neighbour_solid_mask[i] && !(r_2d && i >= 4);
        end
        w_side.active = w_active;
        w_side.x_link = w_use[1] && w_lvl[1][LW-1];
        w_side.y_link = w_use[3] && w_lvl[3][LW-1];
        w_side.z_link = w_use[5] && w_lvl[5][LW-1];
    end

    // stage valids and stage enables
    logic [NSTG-1:0]   r_vld;
    gfps_pkg::t_side   r_side [NSTG];
    logic [NSTG:0]     w_en;
    logic              w_out_en;

    always_comb begin
        w_en[NSTG] = w_out_en;
        for (int i = NSTG - 1; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign i_cell.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_cell.valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // sideband follows the lanes
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= w_side;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (w_en[i]) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // neighbour lanes
    logic [QW-1:0] w_frac [gfps_pkg::NLANE];

    for (genvar k = 0; k < gfps_pkg::NLANE; k++) begin : g_lane
        gfps_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en[NSTG-1:0]),
            .i_a     (w_a),
            .i_level (w_lvl[k]),
            .i_use   (w_use[k]),
            .i_min   (r_min),
            .i_max   (r_max),
            .o_frac  (w_frac[k])
        );
    end

    gfps_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[NSTG-1]),
        .i_frac  (w_frac),
        .i_side  (r_side[NSTG-1]),
        .o_en    (w_out_en),
        .o_row   (o_row)
    );
endmodule
